// ----- design/dgpe_pkg.sv -----
// Shared types, constants and helper functions of the diploid genotype posterior engine.
// Used by every module of the block except dgpe_ram; depends on nothing else.
`default_nettype none
package dgpe_pkg;

   // Widths of the fixed-point datapath.
   localparam int VAL_W = 32;   // Q15.16 stored values
   localparam int T_W   = 34;   // half-phase term plus allele likelihood
   localparam int LSE_W = 36;   // log-sum-exp operands and result
   localparam int SUM_W = 40;   // wide sums before saturation

   // ln(0.5) in Q15.16.
   localparam logic signed [T_W-1:0] LN_HALF = -34'sd45426;

   // Saturation bounds of a signed 32-bit value.
   localparam logic signed [SUM_W-1:0] SAT_MAX = 40'sh007FFFFFFF;
   localparam logic signed [SUM_W-1:0] SAT_MIN = 40'shFF80000000;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_ALLELES = 2'd0,
      REG_SAMPLES = 2'd1,
      REG_PRIOR   = 2'd2
   } reg_index_type;

   // Input modes.
   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_READ   = 2'd1,
      MODE_FINISH = 2'd2
   } mode_type;

   // Work classes handed from the front to the back.
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_CLEAR,
      CMD_STORE,
      CMD_UPDATE,
      CMD_FINISH
   } cmd_kind_type;

   // Back-end sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_UPD_ISSUE,
      ST_UPD_DRAIN,
      ST_FOLD_RD,
      ST_FOLD_DAT,
      ST_FOLD_WAIT,
      ST_POST_RD,
      ST_POST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]               mode;
      logic [5:0]               sample_id;
      logic [2:0]               allele_index;
      logic signed [VAL_W-1:0]  allele_log_lik;
      logic signed [VAL_W-1:0]  phase_one_log;
      logic signed [VAL_W-1:0]  phase_two_log;
   } req_word_type;

   typedef struct packed {
      logic [2:0]               first_allele;
      logic [2:0]               second_allele;
      logic signed [VAL_W-1:0]  log_posterior;
      logic signed [VAL_W-1:0]  sample_log_total;
      logic                     last_of_run;
   } rsp_word_type;

   // One classified item waiting for the back end.
   typedef struct packed {
      cmd_kind_type             kind;
      logic [5:0]               sample;
      logic [2:0]               allele;
      logic                     buf_we;
      logic signed [VAL_W-1:0]  lik;
      logic signed [T_W-1:0]    p1h;
      logic signed [T_W-1:0]    p2h;
   } cmd_type;

   // round(65536*ln(1+exp(-i/4))); zero beyond the last entry.
   function automatic logic [15:0] softplus_q16(input logic [5:0] i);
      logic [15:0] c;
      begin
         case (i)
            6'd0:  c = 16'd45426;
            6'd1:  c = 16'd37745;
            6'd2:  c = 16'd31069;
            6'd3:  c = 16'd25354;
            6'd4:  c = 16'd20530;
            6'd5:  c = 16'd16510;
            6'd6:  c = 16'd13200;
            6'd7:  c = 16'd10500;
            6'd8:  c = 16'd8318;
            6'd9:  c = 16'd6567;
            6'd10: c = 16'd5170;
            6'd11: c = 16'd4062;
            6'd12: c = 16'd3184;
            6'd13: c = 16'd2493;
            6'd14: c = 16'd1950;
            6'd15: c = 16'd1523;
            6'd16: c = 16'd1189;
            6'd17: c = 16'd928;
            6'd18: c = 16'd724;
            6'd19: c = 16'd565;
            6'd20: c = 16'd440;
            6'd21: c = 16'd343;
            6'd22: c = 16'd267;
            6'd23: c = 16'd208;
            6'd24: c = 16'd162;
            6'd25: c = 16'd126;
            6'd26: c = 16'd98;
            6'd27: c = 16'd77;
            6'd28: c = 16'd60;
            6'd29: c = 16'd47;
            6'd30: c = 16'd36;
            6'd31: c = 16'd28;
            6'd32: c = 16'd22;
            default: c = 16'd0;
         endcase
         return c;
      end
   endfunction

   // Clamp a wide sum to the signed 32-bit range.
   function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [VAL_W-1:0] r;
      begin
         if (v > SAT_MAX) begin
            r = SAT_MAX[VAL_W-1:0];
         end else if (v < SAT_MIN) begin
            r = SAT_MIN[VAL_W-1:0];
         end else begin
            r = v[VAL_W-1:0];
         end
         return r;
      end
   endfunction

endpackage
`default_nettype wire

// ----- design/dgpe_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package use.
`default_nettype none
module dgpe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                                         clock,
   input  wire logic                                         we,
   input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]   waddr,
   input  wire logic [WIDTH-1:0]                             wdata,
   input  wire logic                                         re,
   input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]   raddr,
   output logic      [WIDTH-1:0]                             rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ----- design/dgpe_lse.sv -----
// Three-stage pipelined log-sum-exp unit: max plus a table correction.
// Depends on dgpe_pkg for widths and the correction table.
`default_nettype none
module dgpe_lse (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 in_valid,
   input  wire logic signed [dgpe_pkg::LSE_W-1:0]    x,
   input  wire logic signed [dgpe_pkg::LSE_W-1:0]    y,
   output logic                                      out_valid,
   output logic signed [dgpe_pkg::LSE_W-1:0]         result
);
   localparam int W = dgpe_pkg::LSE_W;

   logic [2:0]              v_ff, v_in;
   logic signed [W-1:0]     hi1_ff, hi1_in;
   logic [W:0]              absd1_ff, absd1_in;
   logic signed [W-1:0]     hi2_ff, hi2_in;
   logic [15:0]             c2_ff, c2_in;
   logic signed [W-1:0]     out_ff, out_in;
   logic signed [W:0]       diff;
   logic [W:0]              idx_wide;

   // Stage one: larger operand and the absolute difference.
   always_comb begin
      diff     = {x[W-1], x} - {y[W-1], y};
      hi1_in   = (diff > 0) ? x : y;
      absd1_in = (diff > 0) ? diff : -diff;
   end

   // Stage two: difference in quarter nats, rounded, then table lookup.
   always_comb begin
      idx_wide = (absd1_ff + (W+1)'(8192)) >> 14;
      hi2_in   = hi1_ff;
      if (|idx_wide[W:6]) begin
         c2_in = 16'd0;
      end else begin
         c2_in = dgpe_pkg::softplus_q16(idx_wide[5:0]);
      end
   end

   // Stage three: add the correction.
   always_comb begin
      out_in = hi2_ff + $signed({{(W-16){1'b0}}, c2_ff});
      v_in   = {v_ff[1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      hi1_ff   <= hi1_in;
      absd1_ff <= absd1_in;
      hi2_ff   <= hi2_in;
      c2_ff    <= c2_in;
      out_ff   <= out_in;
   end

   assign out_valid = v_ff[2];
   assign result    = out_ff;
endmodule
`default_nettype wire

// ----- design/dgpe_front.sv -----
// Front end: accepts input words and classifies them into back-end commands.
// Depends on dgpe_pkg for word and command types.
`default_nettype none
module dgpe_front #(
   parameter int MAX_ALLELES = 8,
   parameter int MAX_SAMPLES = 64
) (
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire dgpe_pkg::req_word_type                req_word,
   input  wire logic [3:0]                            na,
   input  wire logic [$clog2(MAX_SAMPLES + 1)-1:0]    ns,
   input  wire logic                                  q_full,
   output logic                                       q_push,
   output dgpe_pkg::cmd_type                          q_cmd
);
   logic in_range;
   logic completes;

   // Sort the word into the work it causes.
   always_comb begin
      in_range  = int'(req_word.sample_id) < int'(ns);
      completes = ({1'b0, req_word.allele_index} + 4'd1) == na;

      q_cmd.sample = req_word.sample_id;
      q_cmd.allele = req_word.allele_index;
      q_cmd.buf_we = int'(req_word.allele_index) < MAX_ALLELES;
      q_cmd.lik    = req_word.allele_log_lik;
      q_cmd.p1h    = {{2{req_word.phase_one_log[31]}}, req_word.phase_one_log}
                     + dgpe_pkg::LN_HALF;
      q_cmd.p2h    = {{2{req_word.phase_two_log[31]}}, req_word.phase_two_log}
                     + dgpe_pkg::LN_HALF;

      case (req_word.mode)
         dgpe_pkg::MODE_CLEAR: begin
            q_cmd.kind = dgpe_pkg::CMD_CLEAR;
         end
         dgpe_pkg::MODE_READ: begin
            q_cmd.kind = (completes && in_range) ? dgpe_pkg::CMD_UPDATE : dgpe_pkg::CMD_STORE;
         end
         dgpe_pkg::MODE_FINISH: begin
            q_cmd.kind = in_range ? dgpe_pkg::CMD_FINISH : dgpe_pkg::CMD_NONE;
         end
         default: begin
            q_cmd.kind = dgpe_pkg::CMD_NONE;
         end
      endcase
   end

   // Words that cause no work are taken and dropped.
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full && (q_cmd.kind != dgpe_pkg::CMD_NONE);
endmodule
`default_nettype wire

// ----- design/dgpe_queue.sv -----
// Two-entry command queue between the front and back ends.
// Depends on dgpe_pkg for the command type.
`default_nettype none
module dgpe_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire dgpe_pkg::cmd_type     push_cmd,
   input  wire logic                  pop,
   output logic                       full,
   output logic                       empty,
   output dgpe_pkg::cmd_type          head
);
   dgpe_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   always_comb begin
      full      = count_ff == 2'd2;
      empty     = count_ff == 2'd0;
      head      = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule
`default_nettype wire

// ----- design/dgpe_back.sv -----
// Back end: sequencer that clears, updates and finishes the genotype table.
// Depends on dgpe_pkg, dgpe_ram and dgpe_lse.
`default_nettype none
module dgpe_back #(
   parameter int MAX_ALLELES = 8,
   parameter int MAX_SAMPLES = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_empty,
   input  wire dgpe_pkg::cmd_type             q_head,
   output logic                               q_pop,
   input  wire logic [3:0]                    na,
   input  wire logic signed [31:0]            prior,
   input  wire logic                          rsp_stall,
   output logic                               rsp_valid,
   output dgpe_pkg::rsp_word_type             rsp_word
);
   localparam int PAIRS = MAX_ALLELES * MAX_ALLELES;
   localparam int DEPTH = MAX_SAMPLES * PAIRS;
   localparam int TAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int BAW   = (MAX_ALLELES > 1) ? $clog2(MAX_ALLELES) : 1;
   localparam int LW    = dgpe_pkg::LSE_W;
   localparam int SW    = dgpe_pkg::SUM_W;
   localparam int TW    = dgpe_pkg::T_W;

   dgpe_pkg::state_type      state_ff, state_in;
   dgpe_pkg::cmd_type        cmd_ff, cmd_in;
   dgpe_pkg::rsp_word_type   rsp_word_ff, rsp_word_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [3:0]               a_ff, a_in, b_ff, b_in;
   logic [TAW-1:0]           clr_ff, clr_in;
   logic signed [LW-1:0]     acc_ff, acc_in;
   logic signed [31:0]       total_ff, total_in;
   logic                     first_ff, first_in;
   logic [3:0]               inflight_ff, inflight_in;

   // Update pipeline registers.
   logic                     rd_v_ff, rd_v_in;
   logic [TAW-1:0]           rd_addr_ff;
   logic                     s1_v_ff;
   logic signed [TW-1:0]     t1_ff, t2_ff;
   logic signed [31:0]       s1_e_ff;
   logic [TAW-1:0]           s1_addr_ff;
   logic signed [31:0]       dly_e_ff [3];
   logic [TAW-1:0]           dly_addr_ff [3];

   // Memory and unit hookup.
   logic                     tab_we, tab_re;
   logic [TAW-1:0]           tab_waddr, tab_raddr;
   logic signed [31:0]       tab_wdata, tab_rdata;
   logic                     buf_we, buf_re;
   logic [BAW-1:0]           buf_waddr;
   logic signed [31:0]       bufa_rdata, bufb_rdata;
   logic                     lse_v, lse_out_v;
   logic signed [LW-1:0]     lse_x, lse_y, lse_out;

   logic                     last_pair;
   logic                     row_end;
   logic                     upd_wr;
   logic                     out_free;
   logic signed [SW-1:0]     post;
   logic signed [SW-1:0]     upd_sum;

   dgpe_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_table (
      .clock (clock),
      .we    (tab_we),
      .waddr (tab_waddr),
      .wdata (tab_wdata),
      .re    (tab_re),
      .raddr (tab_raddr),
      .rdata (tab_rdata)
   );

   // Two copies of the read buffer give the row and column likelihoods together.
   dgpe_ram #(.WIDTH(32), .DEPTH(MAX_ALLELES)) u_buf_row (
      .clock (clock),
      .we    (buf_we),
      .waddr (buf_waddr),
      .wdata (q_head.lik),
      .re    (buf_re),
      .raddr (a_ff[BAW-1:0]),
      .rdata (bufa_rdata)
   );

   dgpe_ram #(.WIDTH(32), .DEPTH(MAX_ALLELES)) u_buf_col (
      .clock (clock),
      .we    (buf_we),
      .waddr (buf_waddr),
      .wdata (q_head.lik),
      .re    (buf_re),
      .raddr (b_ff[BAW-1:0]),
      .rdata (bufb_rdata)
   );

   dgpe_lse u_lse (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lse_v),
      .x         (lse_x),
      .y         (lse_y),
      .out_valid (lse_out_v),
      .result    (lse_out)
   );

   // Pair bookkeeping and the shared table address.
   always_comb begin
      row_end   = (b_ff + 4'd1) == na;
      last_pair = row_end && ((a_ff + 4'd1) == na);
      tab_raddr = TAW'(int'(cmd_ff.sample) * PAIRS + int'(a_ff) * MAX_ALLELES + int'(b_ff));
      out_free  = !rsp_valid_ff || !rsp_stall;
      upd_wr    = lse_out_v && ((state_ff == dgpe_pkg::ST_UPD_ISSUE)
                                || (state_ff == dgpe_pkg::ST_UPD_DRAIN));
      upd_sum   = {{(SW-32){dly_e_ff[2][31]}}, dly_e_ff[2]}
                  + {{(SW-LW){lse_out[LW-1]}}, lse_out};
      post      = {{(SW-32){tab_rdata[31]}}, tab_rdata}
                  - {{(SW-32){total_ff[31]}}, total_ff};
      if (post > 0) begin
         post = '0;
      end
   end

   // Log-sum-exp operands: update terms or the running fold.
   always_comb begin
      if (s1_v_ff) begin
         lse_v = 1'b1;
         lse_x = {{(LW-TW){t1_ff[TW-1]}}, t1_ff};
         lse_y = {{(LW-TW){t2_ff[TW-1]}}, t2_ff};
      end else begin
         lse_v = (state_ff == dgpe_pkg::ST_FOLD_DAT) && !first_ff;
         lse_x = acc_ff;
         lse_y = {{(LW-32){tab_rdata[31]}}, tab_rdata};
      end
   end

   // Sequencer: next state, counters and memory controls.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      clr_in       = clr_ff;
      acc_in       = acc_ff;
      total_in     = total_ff;
      first_in     = first_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_v_in      = 1'b0;
      q_pop        = 1'b0;
      buf_we       = 1'b0;
      buf_waddr    = q_head.allele[BAW-1:0];
      buf_re       = 1'b0;
      tab_re       = 1'b0;
      tab_we       = 1'b0;
      tab_waddr    = dly_addr_ff[2];
      tab_wdata    = dgpe_pkg::sat32(upd_sum);

      case (state_ff)
         dgpe_pkg::ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_head;
               a_in     = 4'd0;
               b_in     = 4'd0;
               clr_in   = '0;
               first_in = 1'b1;
               buf_we   = q_head.buf_we && ((q_head.kind == dgpe_pkg::CMD_STORE)
                                            || (q_head.kind == dgpe_pkg::CMD_UPDATE));
               case (q_head.kind)
                  dgpe_pkg::CMD_CLEAR:  state_in = dgpe_pkg::ST_CLEAR;
                  dgpe_pkg::CMD_UPDATE: state_in = dgpe_pkg::ST_UPD_ISSUE;
                  dgpe_pkg::CMD_FINISH: state_in = dgpe_pkg::ST_FOLD_RD;
                  default:              state_in = dgpe_pkg::ST_IDLE;
               endcase
            end
         end
         dgpe_pkg::ST_CLEAR: begin
            tab_we    = 1'b1;
            tab_waddr = clr_ff;
            tab_wdata = prior;
            if (int'(clr_ff) == DEPTH - 1) begin
               state_in = dgpe_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + TAW'(1);
            end
         end
         dgpe_pkg::ST_UPD_ISSUE: begin
            tab_re  = 1'b1;
            buf_re  = 1'b1;
            rd_v_in = 1'b1;
            tab_we  = upd_wr;
            if (row_end) begin
               b_in = 4'd0;
               a_in = a_ff + 4'd1;
            end else begin
               b_in = b_ff + 4'd1;
            end
            if (last_pair) begin
               state_in = dgpe_pkg::ST_UPD_DRAIN;
            end
         end
         dgpe_pkg::ST_UPD_DRAIN: begin
            tab_we = upd_wr;
            if (inflight_ff == 4'd0) begin
               state_in = dgpe_pkg::ST_IDLE;
            end
         end
         dgpe_pkg::ST_FOLD_RD: begin
            tab_re   = 1'b1;
            state_in = dgpe_pkg::ST_FOLD_DAT;
         end
         dgpe_pkg::ST_FOLD_DAT: begin
            if (first_ff) begin
               first_in = 1'b0;
               acc_in   = {{(LW-32){tab_rdata[31]}}, tab_rdata};
               if (last_pair) begin
                  total_in = tab_rdata;
                  a_in     = 4'd0;
                  b_in     = 4'd0;
                  state_in = dgpe_pkg::ST_POST_RD;
               end else begin
                  if (row_end) begin
                     b_in = 4'd0;
                     a_in = a_ff + 4'd1;
                  end else begin
                     b_in = b_ff + 4'd1;
                  end
                  state_in = dgpe_pkg::ST_FOLD_RD;
               end
            end else begin
               state_in = dgpe_pkg::ST_FOLD_WAIT;
            end
         end
         dgpe_pkg::ST_FOLD_WAIT: begin
            if (lse_out_v) begin
               acc_in = lse_out;
               if (last_pair) begin
                  total_in = dgpe_pkg::sat32({{(SW-LW){lse_out[LW-1]}}, lse_out});
                  a_in     = 4'd0;
                  b_in     = 4'd0;
                  state_in = dgpe_pkg::ST_POST_RD;
               end else begin
                  if (row_end) begin
                     b_in = 4'd0;
                     a_in = a_ff + 4'd1;
                  end else begin
                     b_in = b_ff + 4'd1;
                  end
                  state_in = dgpe_pkg::ST_FOLD_RD;
               end
            end
         end
         dgpe_pkg::ST_POST_RD: begin
            tab_re   = 1'b1;
            state_in = dgpe_pkg::ST_POST_OUT;
         end
         dgpe_pkg::ST_POST_OUT: begin
            if (out_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_word_in.first_allele     = a_ff[2:0];
               rsp_word_in.second_allele    = b_ff[2:0];
               rsp_word_in.log_posterior    = dgpe_pkg::sat32(post);
               rsp_word_in.sample_log_total = total_ff;
               rsp_word_in.last_of_run      = last_pair;
               if (last_pair) begin
                  state_in = dgpe_pkg::ST_IDLE;
               end else begin
                  if (row_end) begin
                     b_in = 4'd0;
                     a_in = a_ff + 4'd1;
                  end else begin
                     b_in = b_ff + 4'd1;
                  end
                  state_in = dgpe_pkg::ST_POST_RD;
               end
            end
         end
         default: begin
            state_in = dgpe_pkg::ST_IDLE;
         end
      endcase

      inflight_in = inflight_ff + {3'd0, rd_v_in} - {3'd0, upd_wr};
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dgpe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rd_v_ff      <= 1'b0;
         s1_v_ff      <= 1'b0;
         inflight_ff  <= 4'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         rd_v_ff      <= rd_v_in;
         s1_v_ff      <= rd_v_ff;
         inflight_ff  <= inflight_in;
      end
   end

   // Payload registers; the delay line lines the entries up with the unit output.
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      a_ff           <= a_in;
      b_ff           <= b_in;
      clr_ff         <= clr_in;
      acc_ff         <= acc_in;
      total_ff       <= total_in;
      first_ff       <= first_in;
      rsp_word_ff    <= rsp_word_in;
      rd_addr_ff     <= tab_raddr;
      t1_ff          <= cmd_ff.p1h + {{(TW-32){bufa_rdata[31]}}, bufa_rdata};
      t2_ff          <= cmd_ff.p2h + {{(TW-32){bufb_rdata[31]}}, bufb_rdata};
      s1_e_ff        <= tab_rdata;
      s1_addr_ff     <= rd_addr_ff;
      dly_e_ff[0]    <= s1_e_ff;
      dly_e_ff[1]    <= dly_e_ff[0];
      dly_e_ff[2]    <= dly_e_ff[1];
      dly_addr_ff[0] <= s1_addr_ff;
      dly_addr_ff[1] <= dly_addr_ff[0];
      dly_addr_ff[2] <= dly_addr_ff[1];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
endmodule
`default_nettype wire

// ----- design/diploid_genotype_posterior_engine.sv -----
// A clear writes all MAX_SAMPLES*MAX_ALLELES^2 table entries, one table entry per cycle
// through the single table write port. A non-completing read word only stores its
// likelihood; a completing read issues one pair per cycle into the update pipeline, then
// drains it. A finish runs a serial log-sum-exp fold over the pairs, then reads the table
// once per result word. A two-word queue decouples input from the sequencer.
// Reset restores the configuration defaults; the table is undefined until a clear.
`default_nettype none
module diploid_genotype_posterior_engine #(
   parameter int MAX_ALLELES = 8,
   parameter int MAX_SAMPLES = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire dgpe_pkg::req_word_type    req_word,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output dgpe_pkg::rsp_word_type         rsp_word,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [3:0]                csr_paddr,
   input  wire logic [31:0]               csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   localparam int NSW = $clog2(MAX_SAMPLES + 1);

   logic [3:0]          alleles_ff, alleles_in;
   logic [6:0]          samples_ff, samples_in;
   logic signed [31:0]  prior_ff, prior_in;
   logic                csr_wr;
   logic [3:0]          na;
   logic [NSW-1:0]      ns;
   logic                q_full, q_empty, q_push, q_pop;
   dgpe_pkg::cmd_type   q_cmd, q_head;

   // Configuration registers.
   always_comb begin
      csr_pready = 1'b1;
      csr_wr     = csr_psel && csr_penable && csr_pwrite;
      alleles_in = alleles_ff;
      samples_in = samples_ff;
      prior_in   = prior_ff;
      csr_prdata = 32'd0;
      case (csr_paddr[3:2])
         dgpe_pkg::REG_ALLELES: begin
            csr_prdata = {28'd0, alleles_ff};
            if (csr_wr) alleles_in = csr_pwdata[3:0];
         end
         dgpe_pkg::REG_SAMPLES: begin
            csr_prdata = {25'd0, samples_ff};
            if (csr_wr) samples_in = csr_pwdata[6:0];
         end
         dgpe_pkg::REG_PRIOR: begin
            csr_prdata = prior_ff;
            if (csr_wr) prior_in = csr_pwdata;
         end
         default: begin
            csr_prdata = 32'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alleles_ff <= 4'd8;
         samples_ff <= 7'd64;
         prior_ff   <= -32'sd272557;
      end else begin
         alleles_ff <= alleles_in;
         samples_ff <= samples_in;
         prior_ff   <= prior_in;
      end
   end

   // Effective allele and sample counts.
   always_comb begin
      if (alleles_ff == 4'd0) begin
         na = 4'd1;
      end else if (int'(alleles_ff) > MAX_ALLELES) begin
         na = 4'(MAX_ALLELES);
      end else begin
         na = alleles_ff;
      end
      if (samples_ff == 7'd0) begin
         ns = NSW'(1);
      end else if (int'(samples_ff) > MAX_SAMPLES) begin
         ns = NSW'(MAX_SAMPLES);
      end else begin
         ns = NSW'(samples_ff);
      end
   end

   dgpe_front #(.MAX_ALLELES(MAX_ALLELES), .MAX_SAMPLES(MAX_SAMPLES)) u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .na        (na),
      .ns        (ns),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   dgpe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   dgpe_back #(.MAX_ALLELES(MAX_ALLELES), .MAX_SAMPLES(MAX_SAMPLES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .na        (na),
      .prior     (prior_ff),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );
endmodule
`default_nettype wire

// ----- verif/genotype_posterior_checker.sv -----
// Checker for the diploid genotype posterior engine: mirrors the register file, keeps its
// own genotype table and predicts every result word. Depends on dgpe_pkg only.
`timescale 1ns / 100ps
module genotype_posterior_checker (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_stall,
   input  wire dgpe_pkg::req_word_type  req_word,
   input  wire logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire dgpe_pkg::rsp_word_type  rsp_word,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [3:0]              csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   input  wire logic                    csr_pready,
   output int                           mismatches,
   output int                           outstanding,
   output int                           words_checked
);

   localparam int NA = 8;
   localparam int NS = 64;
   localparam longint HALF_LOG = -45426;

   // Correction term of log-sum-exp in quarter-nat steps.
   localparam int SOFTPLUS [0:32] = '{
      45426, 37745, 31069, 25354, 20530, 16510, 13200, 10500,
      8318, 6567, 5170, 4062, 3184, 2493, 1950, 1523,
      1189, 928, 724, 565, 440, 343, 267, 208,
      162, 126, 98, 77, 60, 47, 36, 28, 22};

   logic [3:0]              alleles_reg;
   logic [6:0]              samples_reg;
   logic signed [31:0]      prior_reg;
   logic signed [31:0]      genotype_table [0:NS*NA*NA-1];
   logic signed [31:0]      lik_buffer [0:NA-1];
   dgpe_pkg::rsp_word_type  expected_words [$];

   function automatic longint log_sum(input longint x, input longint y);
      longint hi, lo, idx;
      hi = (x > y) ? x : y;
      lo = (x > y) ? y : x;
      idx = (hi - lo + 8192) >>> 14;
      return hi + ((idx < 33) ? SOFTPLUS[idx] : 0);
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic int eff_alleles();
      if (alleles_reg < 1) return 1;
      if (alleles_reg > NA) return NA;
      return alleles_reg;
   endfunction

   function automatic int eff_samples();
      if (samples_reg < 1) return 1;
      if (samples_reg > NS) return NS;
      return samples_reg;
   endfunction

   // Apply one accepted input word to the table and queue any results it causes.
   task automatic apply_word(input dgpe_pkg::req_word_type w);
      int na, ns, base;
      longint t1, t2, acc, post, total;
      dgpe_pkg::rsp_word_type r;
      na = eff_alleles();
      ns = eff_samples();
      base = w.sample_id * NA * NA;
      case (w.mode)
         dgpe_pkg::MODE_CLEAR: begin
            for (int i = 0; i < NS*NA*NA; i++) genotype_table[i] = prior_reg;
         end
         dgpe_pkg::MODE_READ: begin
            lik_buffer[w.allele_index] = w.allele_log_lik;
            if (w.allele_index + 1 == na && w.sample_id < ns) begin
               for (int a = 0; a < na; a++) begin
                  for (int b = 0; b < na; b++) begin
                     t1 = HALF_LOG + longint'(w.phase_one_log) + longint'(lik_buffer[a]);
                     t2 = HALF_LOG + longint'(w.phase_two_log) + longint'(lik_buffer[b]);
                     genotype_table[base + a*NA + b] = 32'(clamp32(
                        longint'(genotype_table[base + a*NA + b]) + log_sum(t1, t2)));
                  end
               end
            end
         end
         dgpe_pkg::MODE_FINISH: begin
            if (w.sample_id < ns) begin
               acc = 0;
               for (int a = 0; a < na; a++)
                  for (int b = 0; b < na; b++)
                     acc = (a == 0 && b == 0) ? longint'(genotype_table[base])
                         : log_sum(acc, longint'(genotype_table[base + a*NA + b]));
               total = clamp32(acc);
               for (int a = 0; a < na; a++) begin
                  for (int b = 0; b < na; b++) begin
                     post = longint'(genotype_table[base + a*NA + b]) - total;
                     if (post > 0) post = 0;
                     r.first_allele = 3'(a);
                     r.second_allele = 3'(b);
                     r.log_posterior = 32'(clamp32(post));
                     r.sample_log_total = 32'(total);
                     r.last_of_run = (a == na-1 && b == na-1);
                     expected_words = {expected_words, r};
                  end
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   // Compare one result word with the oldest expectation.
   task automatic compare_word(input dgpe_pkg::rsp_word_type act);
      dgpe_pkg::rsp_word_type exp_w;
      if (expected_words.size() == 0) begin
         $display("%0t: unexpected result word %h", $time, act);
         mismatches++;
      end else begin
         exp_w = expected_words.pop_front();
         words_checked++;
         if (exp_w.first_allele !== act.first_allele ||
             exp_w.second_allele !== act.second_allele ||
             exp_w.log_posterior !== act.log_posterior ||
             exp_w.sample_log_total !== act.sample_log_total ||
             exp_w.last_of_run !== act.last_of_run) begin
            $display("%0t: result mismatch expected a=%0d b=%0d post=%0d total=%0d last=%0b",
                     $time, exp_w.first_allele, exp_w.second_allele, exp_w.log_posterior,
                     exp_w.sample_log_total, exp_w.last_of_run);
            $display("%0t:                  actual a=%0d b=%0d post=%0d total=%0d last=%0b",
                     $time, act.first_allele, act.second_allele, act.log_posterior,
                     act.sample_log_total, act.last_of_run);
            mismatches++;
         end
      end
   endtask

   initial begin
      mismatches = 0;
      words_checked = 0;
      outstanding = 0;
      for (int i = 0; i < NS*NA*NA; i++) genotype_table[i] = 0;
      for (int i = 0; i < NA; i++) lik_buffer[i] = 0;
   end

   // Watch results, register writes and input words at every edge.
   always @(posedge clock) begin
      if (reset) begin
         alleles_reg <= 4'd8;
         samples_reg <= 7'd64;
         prior_reg <= -32'sd272557;
         expected_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) compare_word(rsp_word);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               dgpe_pkg::REG_ALLELES: alleles_reg <= csr_pwdata[3:0];
               dgpe_pkg::REG_SAMPLES: samples_reg <= csr_pwdata[6:0];
               dgpe_pkg::REG_PRIOR:   prior_reg <= csr_pwdata;
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) apply_word(req_word);
      end
      outstanding = expected_words.size();
   end

endmodule

// ----- verif/diploid_genotype_posterior_engine_test.sv -----
// Top of the genotype posterior engine test: clock, reset, stimulus and verdict.
// Depends on dgpe_pkg, the engine and genotype_posterior_checker.
`timescale 1ns / 100ps
module diploid_genotype_posterior_engine_test;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int SETTLE = 4600;
   localparam int CYCLE_LIMIT = 1500000;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, rsp_valid, rsp_stall = 0;
   dgpe_pkg::req_word_type req_word = '0;
   dgpe_pkg::rsp_word_type rsp_word;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0, csr_pready;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0, csr_prdata;
   int mismatches, outstanding, words_checked;
   int items_sent = 0, cycles = 0, live_alleles = 8, live_samples = 64;
   bit quiet = 0;

   // Register settings of the random phases.
   int alleles_set [5] = '{3, 15, 1, 0, 8};
   int samples_set [5] = '{127, 0, 1, 64, 5};
   logic [31:0] prior_set [5] = '{32'h0, 32'h8000_0000, -32'sd131072, -32'sd272557, 0};

   diploid_genotype_posterior_engine dut (.*);

   genotype_posterior_checker scoreboard (.*);

   always #5 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Result side stalls at random unless in a quiet stretch.
   always @(posedge clock) rsp_stall <= !quiet && ($urandom_range(99) < 22);

   function automatic logic [31:0] rand_log();
      int r;
      r = $urandom_range(99);
      if (r < 5) return 32'h0;
      if (r < 10) return 32'h8000_0000;
      if (r < 20) return $urandom;
      return -$urandom_range(20 * 65536);
   endfunction

   task automatic csr_write(input dgpe_pkg::reg_index_type idx, input logic [31:0] value);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      @(posedge clock);
   endtask

   task automatic send(input dgpe_pkg::req_word_type w);
      if (!quiet && $urandom_range(99) < 22) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_fields(input logic [1:0] mode, input int sample, input int allele,
                              input logic [31:0] lik, input logic [31:0] p1,
                              input logic [31:0] p2);
      dgpe_pkg::req_word_type w;
      w.mode = mode;
      w.sample_id = 6'(sample);
      w.allele_index = 3'(allele);
      w.allele_log_lik = lik;
      w.phase_one_log = p1;
      w.phase_two_log = p2;
      send(w);
   endtask

   // Wait for every result, then for a clear or fold that makes none.
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(input int alleles, input int samples, input logic [31:0] prior);
      drain();
      csr_write(dgpe_pkg::REG_ALLELES, 32'(alleles));
      csr_write(dgpe_pkg::REG_SAMPLES, 32'(samples));
      csr_write(dgpe_pkg::REG_PRIOR, prior);
      live_alleles = (alleles < 1) ? 1 : (alleles > 8) ? 8 : alleles;
      live_samples = (samples < 1) ? 1 : (samples > 64) ? 64 : samples;
   endtask

   // One read: likelihoods for alleles 0..A-1, sometimes cut short.
   task automatic send_read(input int sample, input bit broken);
      int stop;
      stop = broken ? $urandom_range(live_alleles - 1) : live_alleles;
      for (int i = 0; i < stop; i++)
         send_fields(dgpe_pkg::MODE_READ, sample, i, rand_log(), rand_log(), rand_log());
   endtask

   function automatic int pick_sample();
      if ($urandom_range(9) == 0) return $urandom_range(63);
      return $urandom_range(live_samples - 1);
   endfunction

   initial begin
      int phase_items, r;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: fill every buffer entry, hit the extremes, saturate, finish.
      send_fields(dgpe_pkg::MODE_CLEAR, 0, 0, 0, 0, 0);
      for (int i = 0; i < 8; i++)
         send_fields(dgpe_pkg::MODE_READ, 0, i, (i % 2) ? 32'h8000_0000 : 32'h0,
                     32'h0, 32'h8000_0000);
      send_fields(dgpe_pkg::MODE_READ, 63, 7, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_fields(dgpe_pkg::MODE_READ, 63, 7, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_fields(dgpe_pkg::MODE_READ, 5, 7, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_fields(dgpe_pkg::MODE_READ, 5, 7, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_fields(MODE_UNUSED, 63, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_fields(dgpe_pkg::MODE_FINISH, 0, 0, 0, 0, 0);
      send_fields(dgpe_pkg::MODE_FINISH, 63, 0, 0, 0, 0);
      send_fields(dgpe_pkg::MODE_FINISH, 5, 0, 0, 0, 0);
      send_fields(dgpe_pkg::MODE_FINISH, 7, 0, 0, 0, 0);

      // Random phases, each under its own register setting.
      for (int ph = 0; ph < 5; ph++) begin
         configure(alleles_set[ph], samples_set[ph],
                   (ph == 4) ? -$urandom_range(32'h7FFF_FFFF) : prior_set[ph]);
         quiet = (ph == 3);
         send_fields(dgpe_pkg::MODE_CLEAR, $urandom_range(63), $urandom_range(7), $urandom,
                     $urandom, $urandom);
         phase_items = 0;
         while (phase_items < 30) begin
            r = $urandom_range(99);
            if (r < 55) begin
               send_read(pick_sample(), $urandom_range(9) == 0);
               phase_items += live_alleles;
            end else if (r < 75) begin
               send_fields(dgpe_pkg::MODE_FINISH, pick_sample(), $urandom_range(7), $urandom,
                           $urandom, $urandom);
               phase_items++;
            end else if (r < 88) begin
               send_fields(dgpe_pkg::MODE_READ, pick_sample(), $urandom_range(7), rand_log(),
                           rand_log(), rand_log());
               phase_items++;
            end else if (r < 94) begin
               send_fields(MODE_UNUSED, $urandom_range(63), $urandom_range(7),
                           $urandom, $urandom, $urandom);
            end else begin
               send_fields(dgpe_pkg::MODE_CLEAR, 0, 0, 0, 0, 0);
               phase_items++;
            end
            if (ph == 2 && phase_items >= 15 && phase_items < 17) begin
               req_valid <= 0;
               @(posedge clock);
               while (outstanding != 0) @(posedge clock);
            end
         end
         send_fields(dgpe_pkg::MODE_FINISH, $urandom_range(live_samples - 1), 0, 0, 0, 0);
      end

      drain();
      if (outstanding != 0) $display("%0d expected result words never arrived", outstanding);
      $display("sent %0d input words over five register settings, checked %0d result words",
               items_sent, words_checked);
      if (mismatches == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
